/* hdl/byte_text_decoder_newline_normalizer_macros.svh */
// Assertion macros for the byte text decoder.
// Used by the top level; no other dependencies.
`ifndef BYTE_TEXT_DECODER_NEWLINE_NORMALIZER_MACROS_SVH
`define BYTE_TEXT_DECODER_NEWLINE_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/btd_pkg.sv */
// Shared types, constants and code tables of the byte text decoder.
// No dependencies.
package btd_pkg;

    // Selected input encoding
    typedef enum logic [1:0] {
        ENC_UTF8     = 2'd0,
        ENC_LATIN1   = 2'd1,
        ENC_CP1252   = 2'd2,
        ENC_MACROMAN = 2'd3
    } t_enc;

    localparam int CP_W = 21;

    // Characters that take part in newline normalization
    localparam logic [CP_W-1:0] CH_LF  = 21'h00000A;
    localparam logic [CP_W-1:0] CH_FF  = 21'h00000C;
    localparam logic [CP_W-1:0] CH_CR  = 21'h00000D;
    localparam logic [CP_W-1:0] CH_NEL = 21'h000085;
    localparam logic [CP_W-1:0] CH_LS  = 21'h002028;
    localparam logic [CP_W-1:0] CH_PS  = 21'h002029;

    // Lead byte bounds
    localparam logic [7:0] B_ASCII_MAX = 8'h7F;
    localparam logic [7:0] B_LEAD2_MAX = 8'hDF;
    localparam logic [7:0] B_OVERLONG  = 8'hC1;
    localparam logic [7:0] B_LEAD3_MAX = 8'hEF;
    localparam logic [7:0] B_LEAD4_MAX = 8'hF4;
    localparam logic [7:0] B_C1_END    = 8'hA0;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_char;
        logic            malformed;
        logic            last;
    } t_out_item;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]      rem;
        logic [CP_W-1:0] partial;
        logic            seq_bad;
        logic            after_cr;
    } t_dec_state;

    // Code page 1252 mappings for bytes 0x80-0x9F
    localparam logic [15:0] CP1252_HIGH [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    // MacRoman bytes 0x80-0xFF
    localparam logic [15:0] MACROMAN_HIGH [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

endpackage

/* hdl/byte_text_decoder_newline_normalizer.sv */
// Top level of the byte text decoder: handshakes, registers and checks.
// Depends on btd_pkg, btd_decode and the assertion macro header.
//
// Takes one text byte per item and gives at most one code point per item, at a
// sustained rate of one item per clock while the output is not stalled. An item
// is latched in the input register, decoded in one pass through btd_decode, and
// its result written into the output register, which presents it at the output.
// Bytes that only open or continue a UTF-8 sequence, or a LF/NEL swallowed
// after CR, give no result unless they end the text. The input stall follows the
// output stall in the same cycle once both registers are full. The encoding register
// should be written only while no item is in flight; its write port is always ready.
module byte_text_decoder_newline_normalizer
    import btd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input items
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // result items
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    // encoding register write
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    t_enc       r_enc;
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_dec_state r_state;

    t_dec_state n_state;
    t_out_item  dec_result;
    logic       dec_result_valid;
    logic       out_free;
    logic       proc;
    logic       in_accept;

    // Handshake control
    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    btd_decode u_decode (
        .i_enc          (r_enc),
        .i_item         (r_in),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (dec_result),
        .o_result_valid (dec_result_valid)
    );

    // Control state and encoding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc       <= ENC_UTF8;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_enc <= t_enc'(i_cfg_data);
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= proc && dec_result_valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (proc) begin
            r_out <= dec_result;
        end
    end

`include "byte_text_decoder_newline_normalizer_macros.svh"

    `BTD_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, proc && r_in.end_of_text, r_state == '0, "state not cleared after end of text")
    `BTD_ASSERT_NOW(a_end_only_form, i_clk, i_rst_n, r_out_valid && !r_out.has_char, r_out.last && r_out.code_point == '0, "end-only result malformed")
    `BTD_ASSERT_NOW(a_no_raw_break, i_clk, i_rst_n, r_out_valid && r_out.has_char, r_out.code_point != CH_CR && r_out.code_point != CH_NEL && r_out.code_point != CH_LS && r_out.code_point != CH_PS && r_out.code_point != CH_FF, "line break not normalized")
    `BTD_ASSERT_NOW(a_malformed_utf8, i_clk, i_rst_n, r_out_valid && r_out.malformed, r_enc == ENC_UTF8, "malformed flag outside UTF-8")

endmodule

/* hdl/btd_decode.sv */
// Per-byte decode and newline normalization, purely combinational.
// Depends on btd_pkg.
module btd_decode
    import btd_pkg::*;
(
    input  t_enc       i_enc,
    input  t_in_item   i_item,
    input  t_dec_state i_state,
    output t_dec_state o_state,
    output t_out_item  o_result,
    output logic       o_result_valid
);

    always_comb begin
        logic [7:0]      b;
        logic            have;
        logic            bad;
        logic [CP_W-1:0] c;
        logic [1:0]      rem_dec;
        logic [CP_W-1:0] acc;
        logic            acc_bad;
        t_dec_state      st;

        b       = i_item.text_byte;
        have    = 1'b0;
        bad     = 1'b0;
        c       = '0;
        st      = i_state;
        rem_dec = i_state.rem - 2'd1;
        acc     = {i_state.partial[CP_W-7:0], b[5:0]};
        acc_bad = i_state.seq_bad | (b[7:6] != CONT_TAG);

        // Character decode
        unique case (i_enc)
            ENC_UTF8: begin
                if (i_state.rem == 2'd0) begin
                    if (b <= B_ASCII_MAX) begin
                        c    = {13'd0, b};
                        have = 1'b1;
                    end else if (b <= B_LEAD2_MAX) begin
                        st.partial = {16'd0, b[4:0]};
                        st.rem     = 2'd1;
                        st.seq_bad = (b <= B_OVERLONG);
                    end else if (b <= B_LEAD3_MAX) begin
                        st.partial = {17'd0, b[3:0]};
                        st.rem     = 2'd2;
                        st.seq_bad = 1'b0;
                    end else if (b <= B_LEAD4_MAX) begin
                        st.partial = {18'd0, b[2:0]};
                        st.rem     = 2'd3;
                        st.seq_bad = 1'b0;
                    end else begin
                        // lead byte out of range: flagged, code point zero
                        bad  = 1'b1;
                        have = 1'b1;
                    end
                end else begin
                    st.partial = acc;
                    st.seq_bad = acc_bad;
                    st.rem     = rem_dec;
                    if (rem_dec == 2'd0) begin
                        c          = acc;
                        bad        = acc_bad;
                        have       = 1'b1;
                        st.partial = '0;
                        st.seq_bad = 1'b0;
                    end
                end
            end
            ENC_LATIN1: begin
                st.rem     = 2'd0;
                st.partial = '0;
                st.seq_bad = 1'b0;
                c          = {13'd0, b};
                have       = 1'b1;
            end
            ENC_CP1252: begin
                st.rem     = 2'd0;
                st.partial = '0;
                st.seq_bad = 1'b0;
                if (b[7] && b < B_C1_END) begin
                    c = {5'd0, CP1252_HIGH[b[4:0]]};
                end else begin
                    c = {13'd0, b};
                end
                have = 1'b1;
            end
            ENC_MACROMAN: begin
                st.rem     = 2'd0;
                st.partial = '0;
                st.seq_bad = 1'b0;
                if (b[7]) begin
                    c = {5'd0, MACROMAN_HIGH[b[6:0]]};
                end else begin
                    c = {13'd0, b};
                end
                have = 1'b1;
            end
        endcase

        // Newline normalization; CR swallows a following clean LF or NEL
        if (have) begin
            if (i_state.after_cr && !bad && (c == CH_LF || c == CH_NEL)) begin
                have        = 1'b0;
                st.after_cr = 1'b0;
            end else if (c == CH_CR) begin
                c           = CH_LF;
                st.after_cr = 1'b1;
            end else begin
                st.after_cr = 1'b0;
                if (c == CH_NEL || c == CH_FF || c == CH_LS || c == CH_PS) begin
                    c = CH_LF;
                end
            end
        end

        o_result.code_point = have ? c : '0;
        o_result.has_char   = have;
        o_result.malformed  = have ? bad : (st.rem != 2'd0);
        o_result.last       = i_item.end_of_text;
        o_result_valid      = have | i_item.end_of_text;

        // End of text returns all state to zero
        if (i_item.end_of_text) begin
            st = '0;
        end
        o_state = st;
    end

endmodule
